// ===== rtl/longest_match_trie_tokenizer_unit_macros.svh =====
// Assertion helpers for the tokenizer unit.
`ifndef LONGEST_MATCH_TRIE_TOKENIZER_UNIT_MACROS_SVH
`define LONGEST_MATCH_TRIE_TOKENIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LMTU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmtu assertion failed");
`define LMTU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmtu assertion failed");
`else
`define LMTU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define LMTU_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/lmt_pkg.sv =====
package lmt_pkg;
  localparam int BYTE_W  = 8;
  localparam int TOKEN_W = 16;
  localparam int FANOUT  = 256;
  localparam logic [TOKEN_W-1:0] NO_TOKEN = 16'hFFFF;
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TEXT   = 1'b1;
endpackage

// ===== rtl/lmt_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle.
module lmt_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/lmt_lookahead.sv =====
// Lookahead byte buffer: append at the tail, drop a matched prefix.
module lmt_lookahead #(
  parameter int MAX = 16,
  parameter int CW  = 5,
  parameter int IW  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [lmt_pkg::BYTE_W-1:0]  push_byte,
  input  logic                        shift,
  input  logic [CW-1:0]               shift_len,
  input  logic [IW-1:0]               rd_idx,
  output logic [lmt_pkg::BYTE_W-1:0]  rd_byte,
  output logic [CW-1:0]               count
);
  import lmt_pkg::*;

  logic [BYTE_W-1:0] lb [MAX];

  assign rd_byte = lb[rd_idx];

  // byte storage, no reset
  always_ff @(posedge clk) begin
    if (push && (count < CW'(MAX))) begin
      lb[count[IW-1:0]] <= push_byte;
    end else if (shift) begin
      for (int k = 0; k < MAX; k++) begin
        if (k + int'(shift_len) < MAX) begin
          lb[k] <= lb[k + int'(shift_len)];
        end
      end
    end
  end

  // fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push && (count < CW'(MAX))) begin
      count <= count + 1'b1;
    end else if (shift) begin
      count <= count - shift_len;
    end
  end
endmodule

// ===== rtl/longest_match_trie_tokenizer_unit.sv =====
// Channel | Beat fields                                  | Handshake
// in      | action, byte_value, is_last, token_value      | in_valid / in_ready
// out     | token, status, run_end                        | out_valid / out_ready
//
// Insert beat: child read in IDLE, then write back in INS_WR. Text beat: accepted in IDLE,
// then one scan per token plus a final one; a scan starts in SC_START, walks one byte per
// SC_STEP, adds SC_LAST when the walk covers the whole buffer, then decides in DECIDE.
// After reset a clearing pass zeroes all NODE_COUNT*256 entries of the child table;
// in_ready stays low meanwhile. A stalled output holds the next token emission.
module longest_match_trie_tokenizer_unit #(
  parameter int NODE_COUNT    = 1024,
  parameter int MAX_MATCH_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         action,
  input  logic [lmt_pkg::BYTE_W-1:0]   byte_value,
  input  logic                         is_last,
  input  logic [lmt_pkg::TOKEN_W-1:0]  token_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lmt_pkg::TOKEN_W-1:0]  token,
  output logic                         status,
  output logic                         run_end
);
  import lmt_pkg::*;
  `include "longest_match_trie_tokenizer_unit_macros.svh"

  localparam int NW     = $clog2(NODE_COUNT);
  localparam int FW     = $clog2(NODE_COUNT + 1);
  localparam int CAW    = NW + BYTE_W;
  localparam int CDEPTH = NODE_COUNT * FANOUT;
  localparam int CW     = $clog2(MAX_MATCH_LEN + 1);
  localparam int IW     = (MAX_MATCH_LEN > 1) ? $clog2(MAX_MATCH_LEN) : 1;

  typedef enum logic [2:0] {
    CLR, IDLE, INS_WR, SC_START, SC_STEP, SC_LAST, DECIDE
  } state_t;

  state_t state;

  logic [CAW-1:0]     clr_cnt;
  logic [FW-1:0]      nfree;
  logic [NW-1:0]      cursor;
  logic               dropped;
  logic [BYTE_W-1:0]  ins_byte;
  logic               ins_last;
  logic [TOKEN_W-1:0] ins_tok;
  logic               text_last;
  logic [CW-1:0]      scan_idx;
  logic               tokv;
  logic               all_hit;
  logic [CW-1:0]      best_len;
  logic [TOKEN_W-1:0] best_tok;
  logic               pend;
  logic [TOKEN_W-1:0] pend_tok;

  // memory ports
  logic               c_we, c_re, t_we, t_re;
  logic [CAW-1:0]     c_waddr, c_raddr;
  logic [NW-1:0]      c_wdata, c_rdata, t_waddr, t_raddr;
  logic [TOKEN_W-1:0] t_wdata, t_rdata;

  // lookahead ports
  logic               la_push, la_shift;
  logic [CW-1:0]      la_len, la_count;
  logic [IW-1:0]      la_idx;
  logic [BYTE_W-1:0]  la_byte;

  logic               in_beat, out_free, fin;
  logic [CW-1:0]      idx_inc, emit_len;

  lmt_ram #(.DEPTH(CDEPTH), .AW(CAW), .DW(NW)) u_child (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  lmt_ram #(.DEPTH(NODE_COUNT), .AW(NW), .DW(TOKEN_W)) u_token (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
  );

  lmt_lookahead #(.MAX(MAX_MATCH_LEN), .CW(CW), .IW(IW)) u_la (
    .clk, .rst, .push(la_push), .push_byte(byte_value), .shift(la_shift),
    .shift_len(la_len), .rd_idx(la_idx), .rd_byte(la_byte), .count(la_count)
  );

  assign in_ready = (state == IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign idx_inc  = scan_idx + 1'b1;
  assign fin      = (la_count == '0) ||
                    (all_hit && (la_count < CW'(MAX_MATCH_LEN)) && !text_last);
  assign emit_len = (best_len == '0) ? CW'(1) :
                    ((best_len > la_count) ? la_count : best_len);

  // memory and buffer control
  always_comb begin
    c_we = 1'b0; c_waddr = clr_cnt; c_wdata = '0;
    c_re = 1'b0; c_raddr = {cursor, byte_value};
    t_we = 1'b0; t_waddr = c_rdata; t_wdata = NO_TOKEN;
    t_re = 1'b0; t_raddr = c_rdata;
    la_push = 1'b0; la_shift = 1'b0; la_len = emit_len;
    la_idx = (state == SC_STEP) ? idx_inc[IW-1:0] : '0;
    case (state)
      CLR: c_we = 1'b1;
      IDLE: begin
        la_push = in_beat && (action == ACT_TEXT);
        c_re    = in_beat && (action == ACT_INSERT) && !dropped;
      end
      INS_WR: begin
        if (out_free && !dropped) begin
          if (c_rdata == '0) begin
            if (nfree < FW'(NODE_COUNT)) begin
              c_we    = 1'b1;
              c_waddr = {cursor, ins_byte};
              c_wdata = nfree[NW-1:0];
              t_we    = 1'b1;
              t_waddr = nfree[NW-1:0];
              t_wdata = ins_last ? ins_tok : NO_TOKEN;
            end
          end else if (ins_last) begin
            t_we    = 1'b1;
            t_wdata = ins_tok;
          end
        end
      end
      SC_START: begin
        c_re    = (la_count != '0);
        c_raddr = {NW'(0), la_byte};
      end
      SC_STEP: begin
        if (c_rdata != '0) begin
          t_re = 1'b1;
          if (idx_inc < la_count) begin
            c_re    = 1'b1;
            c_raddr = {c_rdata, la_byte};
          end
        end
      end
      DECIDE: la_shift = !fin && (!pend || out_free);
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLR;
      clr_cnt   <= '0;
      nfree     <= FW'(1);
      cursor    <= '0;
      dropped   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CAW'(CDEPTH - 1)) state <= IDLE;
        end
        IDLE: begin
          if (in_beat) begin
            ins_byte  <= byte_value;
            ins_last  <= is_last;
            ins_tok   <= token_value;
            text_last <= is_last;
            state     <= (action == ACT_INSERT) ? INS_WR : SC_START;
          end
        end
        INS_WR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            token     <= '0;
            run_end   <= 1'b1;
            status    <= 1'b0;
            if (dropped) begin
              status <= 1'b1;
            end else if (c_rdata == '0) begin
              if (nfree < FW'(NODE_COUNT)) begin
                cursor <= nfree[NW-1:0];
                nfree  <= nfree + 1'b1;
              end else begin
                status  <= 1'b1;
                dropped <= 1'b1;
              end
            end else begin
              cursor <= c_rdata;
            end
            if (ins_last) begin
              cursor  <= '0;
              dropped <= 1'b0;
            end
            state <= IDLE;
          end
        end
        SC_START: begin
          scan_idx <= '0;
          tokv     <= 1'b0;
          best_len <= '0;
          best_tok <= NO_TOKEN;
          all_hit  <= 1'b1;
          state    <= (la_count == '0) ? DECIDE : SC_STEP;
        end
        SC_STEP: begin
          if (tokv && (t_rdata != NO_TOKEN)) begin
            best_len <= scan_idx;
            best_tok <= t_rdata;
          end
          if (c_rdata == '0) begin
            all_hit <= 1'b0;
            state   <= DECIDE;
          end else if (idx_inc < la_count) begin
            scan_idx <= idx_inc;
            tokv     <= 1'b1;
          end else begin
            state <= SC_LAST;
          end
        end
        SC_LAST: begin
          if (t_rdata != NO_TOKEN) begin
            best_len <= idx_inc;
            best_tok <= t_rdata;
          end
          state <= DECIDE;
        end
        DECIDE: begin
          if (fin) begin
            if (!pend) begin
              state <= IDLE;
            end else if (out_free) begin
              out_valid <= 1'b1;
              token     <= pend_tok;
              status    <= 1'b0;
              run_end   <= 1'b1;
              pend      <= 1'b0;
              state     <= IDLE;
            end
          end else if (!pend || out_free) begin
            if (pend) begin
              out_valid <= 1'b1;
              token     <= pend_tok;
              status    <= 1'b0;
              run_end   <= 1'b0;
            end
            pend     <= 1'b1;
            pend_tok <= (best_len == '0) ? NO_TOKEN : best_tok;
            state    <= SC_START;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `LMTU_ASSERT_IMP(a_idle_no_pend, clk, rst, state == IDLE, !pend)
  `LMTU_ASSERT_IMP(a_nfree_bound, clk, rst, 1'b1, nfree <= FW'(NODE_COUNT))
  `LMTU_ASSERT_NXT(a_text_fills, clk, rst, in_beat && (action == ACT_TEXT), la_count != '0)
endmodule
